>>> sv/apmh_pkg.sv
// Shared types, constants and register codes for the audio peak meter.
package apmh_pkg;

  // Level format: unsigned, 16 fractional bits, 65536 = full scale
  localparam int LVL_W = 17;
  localparam logic [LVL_W-1:0] LVL_FULL = 17'd65536;

  // Envelope fall factor 0.86 in Q0.16
  localparam logic [15:0] ENV_FALL = 16'd56361;
  // Hold time 1.6 s in 1/65536 s
  localparam logic [LVL_W-1:0] HOLD_TIME = 17'd104858;
  // On tick decay, levels below this snap to zero rather than decay
  localparam logic [LVL_W-1:0] SNAP_MIN = 17'd33;

  localparam int SAMPLE_W = 24;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Front-to-back queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register reset values
  localparam logic [CFG_W-1:0] RST_DISPLAY_GAIN = 16'd4096;
  localparam logic [CFG_W-1:0] RST_TICK_STEP    = 16'd1092;
  localparam logic [CFG_W-1:0] RST_HOLD_DECAY   = 16'd63496;
  localparam logic [CFG_W-1:0] RST_LEVEL_DECAY  = 16'd62834;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISPLAY_GAIN = 2'd0,
    REG_TICK_STEP    = 2'd1,
    REG_HOLD_DECAY   = 2'd2,
    REG_LEVEL_DECAY  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  // Classified item passed from front to back
  typedef struct packed {
    cmd_t             cmd;
    logic [LVL_W-1:0] mag;
    logic             block_end;
  } item_t;

  // Ballistics settings used by the back end
  typedef struct packed {
    logic [CFG_W-1:0] tick_step;
    logic [CFG_W-1:0] hold_decay;
    logic [CFG_W-1:0] level_decay;
  } ballistics_cfg_t;

endpackage

>>> sv/apmh_front.sv
// Front end: takes input beats, scales samples to a clamped magnitude.
module apmh_front (
  input  logic                                 in_command,
  input  logic signed [apmh_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_block_end,
  input  logic [apmh_pkg::CFG_W-1:0]           display_gain,
  output apmh_pkg::item_t                      item
);

  localparam int PROD_W = apmh_pkg::SAMPLE_W + apmh_pkg::CFG_W;

  logic [apmh_pkg::SAMPLE_W-1:0] mag;
  logic [PROD_W-1:0]             prod;
  logic [PROD_W-20:0]            scaled;

  // Magnitude; the most negative sample wraps to 2^23, which is what we want
  always_comb begin
    if (in_sample[apmh_pkg::SAMPLE_W-1]) begin
      mag = ~in_sample + 1'b1;
    end else begin
      mag = in_sample;
    end
  end

  // Apply display gain (Q4.12), drop 19 bits, saturate at full scale
  assign prod   = PROD_W'(mag) * PROD_W'(display_gain);
  assign scaled = prod[PROD_W-1:19];

  always_comb begin
    item.cmd       = apmh_pkg::cmd_t'(in_command);
    item.block_end = in_block_end;
    if (scaled > (PROD_W-19)'(apmh_pkg::LVL_FULL)) begin
      item.mag = apmh_pkg::LVL_FULL;
    end else begin
      item.mag = scaled[apmh_pkg::LVL_W-1:0];
    end
  end

endmodule

>>> sv/apmh_queue.sv
// Short FIFO between the front and back ends.
module apmh_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  apmh_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output apmh_pkg::item_t pop_item
);

  apmh_pkg::item_t                    mem_r [apmh_pkg::QDEPTH];
  logic [apmh_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [apmh_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [apmh_pkg::QCNT_W-1:0]        count_r, count_nxt;
  logic                               push, pop;

  assign push_ready = (count_r != apmh_pkg::QCNT_W'(apmh_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      if (wr_ptr_r == apmh_pkg::QPTR_W'(apmh_pkg::QDEPTH - 1)) begin
        wr_ptr_nxt = '0;
      end else begin
        wr_ptr_nxt = wr_ptr_r + 1'b1;
      end
    end
    if (pop) begin
      if (rd_ptr_r == apmh_pkg::QPTR_W'(apmh_pkg::QDEPTH - 1)) begin
        rd_ptr_nxt = '0;
      end else begin
        rd_ptr_nxt = rd_ptr_r + 1'b1;
      end
    end
    count_nxt = count_r + apmh_pkg::QCNT_W'(push) - apmh_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> sv/apmh_back.sv
// Back end: peak tracking, envelope and hold ballistics, output register.
module apmh_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  apmh_pkg::item_t               item,
  input  apmh_pkg::ballistics_cfg_t     cfg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [apmh_pkg::LVL_W-1:0]    out_level,
  output logic [apmh_pkg::LVL_W-1:0]    out_peak_hold
);

  localparam int MUL_W = apmh_pkg::LVL_W + apmh_pkg::CFG_W;

  logic [apmh_pkg::LVL_W-1:0] run_peak_r, run_peak_nxt;
  logic [apmh_pkg::LVL_W-1:0] env_r, env_nxt;
  logic [apmh_pkg::LVL_W-1:0] held_r, held_nxt;
  logic [apmh_pkg::LVL_W-1:0] timer_r, timer_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [apmh_pkg::LVL_W-1:0] out_level_r, out_peak_hold_r;

  logic                       pop;
  logic [apmh_pkg::LVL_W-1:0] pk;
  logic [MUL_W-1:0]           env_fall_prod, env_decay_prod, held_decay_prod;

  assign item_ready = !out_valid_r || out_ready;
  assign pop        = item_valid && item_ready;

  // One multiplier per path, each straight off a state register
  assign env_fall_prod   = MUL_W'(env_r) * MUL_W'(apmh_pkg::ENV_FALL);
  assign env_decay_prod  = MUL_W'(env_r) * MUL_W'(cfg.level_decay);
  assign held_decay_prod = MUL_W'(held_r) * MUL_W'(cfg.hold_decay);

  assign pk = (item.mag > run_peak_r) ? item.mag : run_peak_r;

  // State update for one beat
  always_comb begin
    run_peak_nxt = run_peak_r;
    env_nxt      = env_r;
    held_nxt     = held_r;
    timer_nxt    = timer_r;
    if (pop) begin
      case (item.cmd)
        apmh_pkg::CMD_SAMPLE: begin
          run_peak_nxt = pk;
          if (item.block_end) begin
            if (pk >= env_r) begin
              env_nxt = pk;
            end else begin
              env_nxt = env_fall_prod[MUL_W-1:16];
            end
            if (pk >= held_r) begin
              held_nxt  = pk;
              timer_nxt = apmh_pkg::HOLD_TIME;
            end
            run_peak_nxt = '0;
          end
        end
        apmh_pkg::CMD_TICK: begin
          if (timer_r != '0) begin
            if (timer_r > apmh_pkg::LVL_W'(cfg.tick_step)) begin
              timer_nxt = timer_r - apmh_pkg::LVL_W'(cfg.tick_step);
            end else begin
              timer_nxt = '0;
            end
          end else begin
            held_nxt = (held_r < apmh_pkg::SNAP_MIN) ? '0 : held_decay_prod[MUL_W-1:16];
            env_nxt  = (env_r < apmh_pkg::SNAP_MIN) ? '0 : env_decay_prod[MUL_W-1:16];
          end
        end
        default: begin
          run_peak_nxt = run_peak_r;
        end
      endcase
    end
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_peak_r  <= '0;
      env_r       <= '0;
      held_r      <= '0;
      timer_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      run_peak_r  <= run_peak_nxt;
      env_r       <= env_nxt;
      held_r      <= held_nxt;
      timer_r     <= timer_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    if (pop) begin
      out_level_r     <= env_nxt;
      out_peak_hold_r <= held_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_level     = out_level_r;
  assign out_peak_hold = out_peak_hold_r;

`ifndef SYNTHESIS
  a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
    env_r <= apmh_pkg::LVL_FULL) else $error("envelope above full scale");
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= apmh_pkg::LVL_FULL) else $error("held peak above full scale");
  a_timer_range: assert property (@(posedge clk) disable iff (!rst_n)
    timer_r <= apmh_pkg::HOLD_TIME) else $error("hold timer above hold time");
  a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pop && item.cmd == apmh_pkg::CMD_SAMPLE && item.block_end |=> run_peak_r == '0)
    else $error("running peak not cleared at block end");
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_level_r == env_r && out_peak_hold_r == held_r)
    else $error("result beat does not match updated state");
`endif

endmodule

>>> sv/audio_peak_meter_with_hold.sv
// Audio peak meter with hold: input beats pass through the queue, then the back-end output register.
// Throughput one item per cycle while out_ready is high; the state registers feed their own update.
// A two-entry queue decouples the front from the back; stalls propagate back.
// Reset (rst_n low, synchronous) clears peaks, envelope, hold timer, queue
// and output valid, and loads the register defaults.
module audio_peak_meter_with_hold (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_command,
  input  logic signed [apmh_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                                   in_block_end,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [apmh_pkg::LVL_W-1:0]             out_level,
  output logic [apmh_pkg::LVL_W-1:0]             out_peak_hold,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [apmh_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [apmh_pkg::CFG_W-1:0]             cfg_data
);

  logic [apmh_pkg::CFG_W-1:0] display_gain_r, tick_step_r, hold_decay_r, level_decay_r;
  apmh_pkg::ballistics_cfg_t  bcfg;
  apmh_pkg::item_t            front_item, back_item;
  logic                       back_valid, back_ready;

  // Register file; writes always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_gain_r <= apmh_pkg::RST_DISPLAY_GAIN;
      tick_step_r    <= apmh_pkg::RST_TICK_STEP;
      hold_decay_r   <= apmh_pkg::RST_HOLD_DECAY;
      level_decay_r  <= apmh_pkg::RST_LEVEL_DECAY;
    end else if (cfg_valid) begin
      case (apmh_pkg::cfg_reg_t'(cfg_index))
        apmh_pkg::REG_DISPLAY_GAIN: display_gain_r <= cfg_data;
        apmh_pkg::REG_TICK_STEP:    tick_step_r    <= cfg_data;
        apmh_pkg::REG_HOLD_DECAY:   hold_decay_r   <= cfg_data;
        apmh_pkg::REG_LEVEL_DECAY:  level_decay_r  <= cfg_data;
        default: begin
          display_gain_r <= display_gain_r;
        end
      endcase
    end
  end

  assign bcfg.tick_step   = tick_step_r;
  assign bcfg.hold_decay  = hold_decay_r;
  assign bcfg.level_decay = level_decay_r;

  apmh_front u_front (
    .in_command   (in_command),
    .in_sample    (in_sample),
    .in_block_end (in_block_end),
    .display_gain (display_gain_r),
    .item         (front_item)
  );

  apmh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_item   (back_item)
  );

  apmh_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (back_valid),
    .item_ready    (back_ready),
    .item          (back_item),
    .cfg           (bcfg),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_level     (out_level),
    .out_peak_hold (out_peak_hold)
  );

endmodule
